FILE: hdl/portal_match_list_engine_top_macros.svh
// Assertion macros for the match list engine top level.
`ifndef PORTAL_MATCH_LIST_ENGINE_TOP_MACROS_SVH
`define PORTAL_MATCH_LIST_ENGINE_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define PMLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PMLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pmle_pkg.sv
// Shared types, codes and helper functions of the match list engine.
package pmle_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  // Command codes on the input tuser
  localparam logic [1:0] CMD_POST = 2'd0;
  localparam logic [1:0] CMD_PUT  = 2'd1;
  localparam logic [1:0] CMD_GET  = 2'd2;

  // Result status codes on the output tuser
  localparam logic [2:0] ST_MATCHED  = 3'd0;
  localparam logic [2:0] ST_TOO_BIG  = 3'd1;
  localparam logic [2:0] ST_NO_MATCH = 3'd2;
  localparam logic [2:0] ST_POSTED   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Option bit positions
  localparam int unsigned OPT_PUT         = 0;
  localparam int unsigned OPT_GET         = 1;
  localparam int unsigned OPT_REMOTE_OFF  = 2;
  localparam int unsigned OPT_MAX_SIZE    = 3;
  localparam int unsigned OPT_TRUNCATE    = 4;
  localparam int unsigned OPT_AUTO_UNLINK = 5;
  localparam int unsigned OPT_ANY_NID     = 6;
  localparam int unsigned OPT_ANY_PID     = 7;

  localparam logic [7:0] THR_UNLIMITED = 8'hFF;

  // Table write data selection
  localparam logic [1:0] WSEL_POST  = 2'd0;
  localparam logic [1:0] WSEL_UPD   = 2'd1;
  localparam logic [1:0] WSEL_SHIFT = 2'd2;

  localparam int unsigned IN_TDATA_W  = 336;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned SLOT_W      = 4;

  // One table entry; also holds a latched input word
  typedef struct packed {
    logic [63:0] nid;
    logic [31:0] pid;
    logic [63:0] mbits;
    logic [63:0] ibits;
    logic [31:0] length;
    logic [31:0] offset;
    logic [31:0] max_size;
    logic [7:0]  options;
    logic [7:0]  threshold;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic              load_in;
    logic              ev_en;
    logic              gr_en;
    logic              res_load;
    logic              res_match;
    logic [2:0]        res_status;
    logic [SLOT_W-1:0] res_slot;
    logic [1:0]        wsel;
    logic              out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       too_big;
    logic       unl;
  } dp_sts_t;

  // Remaining buffer space, saturating at zero
  function automatic logic [31:0] space_left(entry_t e);
    return (e.length > e.offset) ? (e.length - e.offset) : 32'd0;
  endfunction

  function automatic logic exhausted(entry_t e);
    return (e.threshold == 8'd0) ||
           (e.options[OPT_MAX_SIZE] && (space_left(e) < e.max_size));
  endfunction

endpackage

FILE: hdl/portal_match_list_engine_top.sv
// Top level of the posted receive match list engine.
// A post or refused word passes the input latch, dispatch and the output register; a
// message adds a scan of each entry (table read, evaluate, grant), a check and update
// for a match, and a read and a write per entry moved down after an unlink.
// Throughput: one word at a time; each scanned entry costs one registered table read.
// Reset clears the entry count and control state; table contents are not cleared.
`include "portal_match_list_engine_top_macros.svh"
module portal_match_list_engine_top #(
  parameter int unsigned ENTRIES = pmle_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // peer_nid, peer_pid, tag bits, mask bits, length, offset, max_size,
  // options, threshold
  input  logic [pmle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command
  input  logic [pmle_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // slot, data_offset, granted_length, unlinked, zero pad
  output logic [pmle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status
  output logic [pmle_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  pmle_pkg::dp_cmd_t dp_cmd;
  pmle_pkg::dp_sts_t dp_sts;
  pmle_pkg::entry_t  ram_rdata, ram_wdata;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [CNT_W-1:0]  cnt;

  pmle_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .cnt_o       (cnt)
  );

  pmle_dp u_dp (
    .clk_i       (clk_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .ram_rdata_i (ram_rdata),
    .ram_wdata_o (ram_wdata),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  // Entry table
  pmle_ram #(.WIDTH(pmle_pkg::ENTRY_W), .DEPTH(1 << IDX_W)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks
  `PMLE_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(ENTRIES), "entry count beyond table size")
  `PMLE_ASSERT_ALWAYS(a_wr_in_use, !ram_we || (CNT_W'(ram_waddr) <= cnt), "write beyond count")
  `PMLE_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `PMLE_ASSERT_ALWAYS(a_one_port, !(ram_we && ram_re), "table read and written at once")

endmodule

FILE: hdl/pmle_ram.sv
// Generic single write port, single read port RAM with registered read.
module pmle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pmle_dp.sv
// Datapath: latched word, entry evaluation, grant and offset update, results.
module pmle_dp (
  input  logic                                clk_i,
  input  logic [pmle_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic [pmle_pkg::IN_TUSER_W-1:0]     s_tuser_i,
  input  pmle_pkg::dp_cmd_t                   cmd_i,
  output pmle_pkg::dp_sts_t                   sts_o,
  input  pmle_pkg::entry_t                    ram_rdata_i,
  output pmle_pkg::entry_t                    ram_wdata_o,
  output logic [pmle_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic [pmle_pkg::OUT_TUSER_W-1:0]    m_tuser_o
);

  logic [1:0]       cmd_q;
  pmle_pkg::entry_t msg_q;
  pmle_pkg::entry_t ent_q, upd_q;
  logic             hit_q;
  logic [31:0]      doff_q, cap_q, grant_q;

  logic [2:0]                      pend_status_q;
  logic [pmle_pkg::SLOT_W-1:0]     pend_slot_q;
  logic [31:0]                     pend_doff_q, pend_grant_q;
  logic                            pend_unl_q;
  logic [pmle_pkg::OUT_TDATA_W-1:0] m_tdata_q;
  logic [pmle_pkg::OUT_TUSER_W-1:0] m_tuser_q;

  pmle_pkg::entry_t e;
  pmle_pkg::entry_t upd_c;
  logic        op_ok, nid_ok, pid_ok, mb_ok, hit_c;
  logic [31:0] doff_c, cap_c, grant_c;
  logic        fits_c;
  logic [32:0] sum_c;
  logic [7:0]  thr_c;
  logic        unl_c;

  // Evaluation of the entry just read
  always_comb begin
    e      = ram_rdata_i;
    op_ok  = ((cmd_q == pmle_pkg::CMD_PUT) && e.options[pmle_pkg::OPT_PUT]) ||
             ((cmd_q == pmle_pkg::CMD_GET) && e.options[pmle_pkg::OPT_GET]);
    nid_ok = e.options[pmle_pkg::OPT_ANY_NID] || (e.nid == msg_q.nid);
    pid_ok = e.options[pmle_pkg::OPT_ANY_PID] || (e.pid == msg_q.pid);
    mb_ok  = ((e.mbits ^ msg_q.mbits) & ~e.ibits) == 64'd0;
    hit_c  = op_ok && !pmle_pkg::exhausted(e) && nid_ok && pid_ok && mb_ok;
    doff_c = e.options[pmle_pkg::OPT_REMOTE_OFF] ? msg_q.offset : e.offset;
    if (e.options[pmle_pkg::OPT_MAX_SIZE]) begin
      cap_c = e.max_size;
    end else begin
      cap_c = (e.length > doff_c) ? (e.length - doff_c) : 32'd0;
    end
  end

  // Grant, saturating offset advance and threshold count-down
  always_comb begin
    fits_c  = msg_q.length <= cap_q;
    grant_c = fits_c ? msg_q.length : cap_q;
    sum_c   = {1'b0, doff_q} + {1'b0, grant_c};
    thr_c   = ent_q.threshold;
    if ((thr_c != pmle_pkg::THR_UNLIMITED) && (thr_c != 8'd0)) begin
      thr_c = thr_c - 8'd1;
    end
    upd_c           = ent_q;
    upd_c.offset    = sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0];
    upd_c.threshold = thr_c;
    unl_c = upd_q.options[pmle_pkg::OPT_AUTO_UNLINK] && pmle_pkg::exhausted(upd_q);
  end

  // Input word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q           <= s_tuser_i;
      msg_q.nid       <= s_tdata_i[63:0];
      msg_q.pid       <= s_tdata_i[95:64];
      msg_q.mbits     <= s_tdata_i[159:96];
      msg_q.ibits     <= s_tdata_i[223:160];
      msg_q.length    <= s_tdata_i[255:224];
      msg_q.offset    <= s_tdata_i[287:256];
      msg_q.max_size  <= s_tdata_i[319:288];
      msg_q.options   <= s_tdata_i[327:320];
      msg_q.threshold <= s_tdata_i[335:328];
    end
  end

  // Scan stage registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_en) begin
      ent_q  <= e;
      hit_q  <= hit_c;
      doff_q <= doff_c;
      cap_q  <= cap_c;
    end
    if (cmd_i.gr_en) begin
      upd_q   <= upd_c;
      grant_q <= grant_c;
    end
  end

  // Pending result and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      pend_status_q <= cmd_i.res_status;
      pend_slot_q   <= cmd_i.res_slot;
      pend_doff_q   <= cmd_i.res_match ? doff_q : 32'd0;
      pend_grant_q  <= cmd_i.res_match ? grant_q : 32'd0;
      pend_unl_q    <= cmd_i.res_match && unl_c;
    end
    if (cmd_i.out_load) begin
      m_tdata_q <= {3'd0, pend_unl_q, pend_grant_q, pend_doff_q, pend_slot_q};
      m_tuser_q <= pend_status_q;
    end
  end

  // Table write data
  always_comb begin
    case (cmd_i.wsel)
      pmle_pkg::WSEL_POST:  ram_wdata_o = msg_q;
      pmle_pkg::WSEL_UPD:   ram_wdata_o = upd_q;
      pmle_pkg::WSEL_SHIFT: ram_wdata_o = ram_rdata_i;
      default:              ram_wdata_o = msg_q;
    endcase
  end

  assign sts_o.cmd     = cmd_q;
  assign sts_o.hit     = hit_q;
  assign sts_o.too_big = !fits_c && !ent_q.options[pmle_pkg::OPT_TRUNCATE];
  assign sts_o.unl     = unl_c;
  assign m_tdata_o     = m_tdata_q;
  assign m_tuser_o     = m_tuser_q;

endmodule

FILE: hdl/pmle_ctrl.sv
// Controller: sequencing of post, scan, update and unlink shift, entry count.
module pmle_ctrl #(
  parameter int unsigned ENTRIES = pmle_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  input  pmle_pkg::dp_sts_t sts_i,
  output pmle_pkg::dp_cmd_t cmd_o,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output logic              ram_re_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  output logic [CNT_W-1:0]  cnt_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_GR   = 4'd4;
  localparam logic [3:0] S_CK   = 4'd5;
  localparam logic [3:0] S_SHR  = 4'd6;
  localparam logic [3:0] S_SHW  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mval_q, mval_d;
  logic [CNT_W-1:0] idx_p1;

  assign idx_p1 = CNT_W'(idx_q) + CNT_W'(1);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    mval_d      = mval_q && !m_tready_i;
    cmd_o       = '0;
    cmd_o.wsel  = pmle_pkg::WSEL_POST;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_DONE;
        idx_d          = '0;
        if (sts_i.cmd == pmle_pkg::CMD_POST) begin
          if (cnt_q == CNT_W'(ENTRIES)) begin
            cmd_o.res_status = pmle_pkg::ST_FULL;
          end else begin
            ram_we_o         = 1'b1;
            ram_waddr_o      = cnt_q[IDX_W-1:0];
            cmd_o.res_status = pmle_pkg::ST_POSTED;
            cmd_o.res_slot   = pmle_pkg::SLOT_W'(cnt_q);
            cnt_d            = cnt_q + CNT_W'(1);
          end
        end else if (cnt_q == '0) begin
          cmd_o.res_status = pmle_pkg::ST_NO_MATCH;
        end else begin
          cmd_o.res_load = 1'b0;
          state_d        = S_RD;
        end
      end
      S_RD: begin
        ram_re_o = 1'b1;
        state_d  = S_EV;
      end
      S_EV: begin
        cmd_o.ev_en = 1'b1;
        state_d     = S_GR;
      end
      S_GR: begin
        if (!sts_i.hit) begin
          if (idx_p1 < cnt_q) begin
            idx_d   = idx_p1[IDX_W-1:0];
            state_d = S_RD;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = pmle_pkg::ST_NO_MATCH;
            state_d          = S_DONE;
          end
        end else if (sts_i.too_big) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = pmle_pkg::ST_TOO_BIG;
          cmd_o.res_slot   = pmle_pkg::SLOT_W'(idx_q);
          state_d          = S_DONE;
        end else begin
          cmd_o.gr_en = 1'b1;
          state_d     = S_CK;
        end
      end
      S_CK: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_match  = 1'b1;
        cmd_o.res_status = pmle_pkg::ST_MATCHED;
        cmd_o.res_slot   = pmle_pkg::SLOT_W'(idx_q);
        state_d          = S_DONE;
        if (!sts_i.unl) begin
          ram_we_o   = 1'b1;
          cmd_o.wsel = pmle_pkg::WSEL_UPD;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          if (idx_p1 < cnt_q) begin
            state_d = S_SHR;
          end
        end
      end
      // Close the gap left by an unlinked entry, one entry per pass
      S_SHR: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_p1[IDX_W-1:0];
        state_d     = S_SHW;
      end
      S_SHW: begin
        ram_we_o   = 1'b1;
        cmd_o.wsel = pmle_pkg::WSEL_SHIFT;
        if (idx_p1 < cnt_q) begin
          idx_d   = idx_p1[IDX_W-1:0];
          state_d = S_SHR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!mval_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          mval_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      mval_q  <= mval_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = mval_q;
  assign cnt_o      = cnt_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the posted receive match list engine.
module tb_top;

  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam int unsigned NSLOT     = pmle_pkg::ENTRIES_DEF;
  localparam int unsigned CYC_LIMIT = 2_000_000;
  localparam int unsigned SETTLE    = 120;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] doff;
    logic [31:0] glen;
    logic        unl;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [pmle_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [pmle_pkg::IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [pmle_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [pmle_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  portal_match_list_engine_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the match table
  pmle_pkg::entry_t shadow_tbl [NSLOT];
  int unsigned shadow_cnt = 0;
  verdict_t    verdict_q [$];
  int unsigned fails = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  int unsigned n_match = 0, n_unl = 0, n_big = 0, n_full = 0;
  bit          calm = 1'b0;
  logic [63:0] nid_pool [4];
  logic [31:0] pid_pool [4];
  logic [63:0] mb_pool  [4];

  function automatic logic [31:0] room_of(pmle_pkg::entry_t e);
    return (e.length > e.offset) ? e.length - e.offset : 32'd0;
  endfunction

  function automatic bit spent(pmle_pkg::entry_t e);
    return (e.threshold == 8'd0) ||
           (e.options[pmle_pkg::OPT_MAX_SIZE] && room_of(e) < e.max_size);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Expected response of one word; updates the shadow table
  task automatic match_predict(input logic [1:0] cmd, input pmle_pkg::entry_t w,
                               output verdict_t r);
    bit               done;
    bit               allow;
    pmle_pkg::entry_t t;
    logic [31:0]      doff, cap, grant;
    logic [32:0]      sum;
    r = '{pmle_pkg::ST_NO_MATCH, 4'd0, 32'd0, 32'd0, 1'b0};
    done = 1'b0;
    if (cmd == pmle_pkg::CMD_POST) begin
      if (shadow_cnt >= NSLOT) begin
        r.status = pmle_pkg::ST_FULL;
      end else begin
        shadow_tbl[shadow_cnt] = w;
        r.status = pmle_pkg::ST_POSTED;
        r.slot = shadow_cnt[3:0];
        shadow_cnt++;
      end
    end else begin
      for (int unsigned e = 0; e < shadow_cnt && !done; e++) begin
        t = shadow_tbl[e];
        allow = (cmd == pmle_pkg::CMD_PUT) ? t.options[pmle_pkg::OPT_PUT] :
                (cmd == pmle_pkg::CMD_GET) ? t.options[pmle_pkg::OPT_GET] : 1'b0;
        if (!allow || spent(t)) continue;
        if (!t.options[pmle_pkg::OPT_ANY_NID] && t.nid != w.nid) continue;
        if (!t.options[pmle_pkg::OPT_ANY_PID] && t.pid != w.pid) continue;
        if (((t.mbits ^ w.mbits) & ~t.ibits) != 64'd0) continue;
        done = 1'b1;
        doff = t.options[pmle_pkg::OPT_REMOTE_OFF] ? w.offset : t.offset;
        if (t.options[pmle_pkg::OPT_MAX_SIZE]) cap = t.max_size;
        else cap = (t.length > doff) ? t.length - doff : 32'd0;
        r.slot = e[3:0];
        if (w.length > cap && !t.options[pmle_pkg::OPT_TRUNCATE]) begin
          r.status = pmle_pkg::ST_TOO_BIG;
        end else begin
          grant = (w.length <= cap) ? w.length : cap;
          sum = {1'b0, doff} + {1'b0, grant};
          t.offset = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (t.threshold != pmle_pkg::THR_UNLIMITED && t.threshold != 8'd0) t.threshold--;
          shadow_tbl[e] = t;
          r.status = pmle_pkg::ST_MATCHED;
          r.doff = doff;
          r.glen = grant;
          if (t.options[pmle_pkg::OPT_AUTO_UNLINK] && spent(t)) begin
            for (int unsigned i = e; i + 1 < shadow_cnt; i++) shadow_tbl[i] = shadow_tbl[i + 1];
            shadow_cnt--;
            r.unl = 1'b1;
          end
        end
      end
    end
  endtask

  // Drive one word, wait for acceptance, queue its expected response
  task automatic send_word(input logic [1:0] cmd, input pmle_pkg::entry_t w);
    verdict_t r;
    if (!calm && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {w.threshold, w.options, w.max_size, w.offset, w.length,
                     w.ibits, w.mbits, w.pid, w.nid};
    do @(posedge clk_i); while (!s_axis_tready);
    match_predict(cmd, w, r);
    verdict_q.push_back(r);
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_wait();
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic pmle_pkg::entry_t blank_word();
    pmle_pkg::entry_t w;
    w = '0;
    return w;
  endfunction

  // Matching, too-large, truncation, saturation, full table, spare command
  task automatic test_directed();
    pmle_pkg::entry_t w;
    w = blank_word();
    send_word(pmle_pkg::CMD_PUT, w);                // empty table
    w = '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
          32'd100, 32'd0, 32'd0, 8'h21, 8'd2};
    send_word(pmle_pkg::CMD_POST, w);
    w.length = 32'd40;
    send_word(pmle_pkg::CMD_GET, w);                // get not allowed
    send_word(pmle_pkg::CMD_PUT, w);
    w.length = 32'd80;
    send_word(pmle_pkg::CMD_PUT, w);                // too large
    w.length = 32'd60;
    send_word(pmle_pkg::CMD_PUT, w);                // threshold runs out, unlinked
    // remote offset, max-size, truncation and offset saturation
    w = '{64'd0, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h30, 32'd0, 32'h10, 8'hFE, 8'hFF};
    send_word(pmle_pkg::CMD_POST, w);
    w = '{rand64(), $urandom, rand64(), 64'd0, 32'h20, 32'hFFFF_FFF8, 32'd0, 8'd0, 8'd0};
    send_word(pmle_pkg::CMD_GET, w);
    w = '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF};
    send_word(CMD_SPARE, w);
    // dead entry with zero threshold stays put at slot 0
    w = blank_word();
    w.options = 8'h01;
    send_word(pmle_pkg::CMD_POST, w);
    send_word(pmle_pkg::CMD_PUT, w);
    // fill the table, then one more post is refused
    w = '{64'd0, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h40, 32'd0, 32'd0, 8'hE1, 8'd1};
    repeat (NSLOT) send_word(pmle_pkg::CMD_POST, w);
    w = blank_word();
    repeat (NSLOT - 1) send_word(pmle_pkg::CMD_PUT, w);
  endtask

  task automatic post_random();
    pmle_pkg::entry_t w;
    logic [31:0]      rm;
    w.nid   = ($urandom_range(0, 9) == 0) ? rand64() : nid_pool[$urandom_range(0, 3)];
    w.pid   = ($urandom_range(0, 9) == 0) ? $urandom : pid_pool[$urandom_range(0, 3)];
    w.mbits = mb_pool[$urandom_range(0, 3)];
    w.ibits = $urandom_range(0, 1) ? 64'd0 : rand64();
    w.length = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4096);
    w.offset = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, w.length);
    w.options = 8'($urandom_range(0, 255));
    w.options[pmle_pkg::OPT_AUTO_UNLINK] = 1'b1;
    if (!w.options[pmle_pkg::OPT_PUT] && !w.options[pmle_pkg::OPT_GET])
      w.options[pmle_pkg::OPT_PUT] = 1'b1;
    rm = room_of(w);
    if (rm == 0) w.options[pmle_pkg::OPT_MAX_SIZE] = 1'b0;
    w.max_size = w.options[pmle_pkg::OPT_MAX_SIZE] ?
                 $urandom_range(1, (rm > 512) ? 512 : rm) : $urandom;
    w.threshold = (w.options[pmle_pkg::OPT_MAX_SIZE] && $urandom_range(0, 2) == 0)
                  ? pmle_pkg::THR_UNLIMITED : 8'($urandom_range(1, 4));
    send_word(pmle_pkg::CMD_POST, w);
  endtask

  task automatic message_random();
    pmle_pkg::entry_t w;
    pmle_pkg::entry_t t;
    logic [1:0]       cmd;
    logic [31:0]      base;
    w = '{rand64(), $urandom, rand64(), rand64(), $urandom, $urandom, $urandom,
          8'($urandom), 8'($urandom)};
    cmd = 2'($urandom_range(1, 3));
    if (shadow_cnt > 1 && $urandom_range(0, 99) < 80) begin
      t = shadow_tbl[$urandom_range(1, shadow_cnt - 1)];
      cmd = t.options[pmle_pkg::OPT_PUT] ? pmle_pkg::CMD_PUT : pmle_pkg::CMD_GET;
      if (t.options[pmle_pkg::OPT_PUT] && t.options[pmle_pkg::OPT_GET] &&
          $urandom_range(0, 1)) cmd = pmle_pkg::CMD_GET;
      if (!t.options[pmle_pkg::OPT_ANY_NID]) w.nid = t.nid;
      if (!t.options[pmle_pkg::OPT_ANY_PID]) w.pid = t.pid;
      w.mbits = t.mbits ^ (rand64() & t.ibits);
      base = t.options[pmle_pkg::OPT_MAX_SIZE] ? t.max_size : room_of(t);
      if (base > 32'd100000) base = 32'd100000;
      w.length = $urandom_range(0, 2 * base + 4);
      if ($urandom_range(0, 3) != 0) w.offset = $urandom_range(0, t.length);
    end
    send_word(cmd, w);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      calm = (k >= count / 3) && (k < count / 2);
      if ($urandom_range(0, 99) < 30) post_random();
      else message_random();
    end
    calm = 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    verdict_t x;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (verdict_q.size() == 0) begin
        $error("response with none outstanding");
        fails++;
      end else begin
        x = verdict_q.pop_front();
        if (m_axis_tuser != x.status) begin
          $error("status: expected %0d actual %0d", x.status, m_axis_tuser); fails++;
        end
        if (m_axis_tdata[3:0] != x.slot) begin
          $error("slot: expected %0d actual %0d", x.slot, m_axis_tdata[3:0]); fails++;
        end
        if (m_axis_tdata[35:4] != x.doff) begin
          $error("data_offset: expected %h actual %h", x.doff, m_axis_tdata[35:4]); fails++;
        end
        if (m_axis_tdata[67:36] != x.glen) begin
          $error("granted_length: expected %h actual %h", x.glen, m_axis_tdata[67:36]);
          fails++;
        end
        if (m_axis_tdata[68] != x.unl) begin
          $error("unlinked: expected %0d actual %0d", x.unl, m_axis_tdata[68]); fails++;
        end
        case (x.status)
          pmle_pkg::ST_MATCHED: begin
            n_match++;
            if (x.unl) n_unl++;
          end
          pmle_pkg::ST_TOO_BIG: n_big++;
          pmle_pkg::ST_FULL:    n_full++;
          default:              ;
        endcase
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
  end

  // Run watchdog
  always @(posedge clk_i) begin
    int unsigned cyc;
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("portal_match_list_engine_top test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      nid_pool[i] = rand64();
      pid_pool[i] = $urandom;
      mb_pool[i]  = rand64();
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    drain_wait();
    test_random(700);
    drain_wait();
    test_random(700);
    drain_wait();
    $display("Sent %0d words, checked %0d responses: %0d matched, %0d unlinked,",
             words_sent, words_seen, n_match, n_unl);
    $display("%0d dropped as too large, %0d refused on a full table", n_big, n_full);
    if (fails == 0 && verdict_q.size() == 0) begin
      $display("portal_match_list_engine_top test passed");
    end else begin
      $display("portal_match_list_engine_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/pmle_pkg.sv
hdl/pmle_ram.sv
hdl/pmle_dp.sv
hdl/pmle_ctrl.sv
hdl/portal_match_list_engine_top.sv
sim/tb_top.sv
